>>> src/spc_pkg.sv
// shared types, constants and control program of the strided prime counter
package spc_pkg;

   // result and configuration widths
   localparam int COUNT_W = 13;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
   localparam int OFFSET_W = 6;
   localparam int STRIDE_W = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_START_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_COUNT = 2'd1;

   // first candidate base and first trial divisor
   localparam int FIRST_CANDIDATE = 2;
   localparam int FIRST_DIVISOR = 2;

   // program counter and program addresses
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] ADDR_IDLE       = 4'd0;
   localparam logic [PC_W-1:0] ADDR_CHECK_CAND = 4'd1;
   localparam logic [PC_W-1:0] ADDR_CHECK_DIV  = 4'd2;
   localparam logic [PC_W-1:0] ADDR_WAIT_DIV   = 4'd3;
   localparam logic [PC_W-1:0] ADDR_TEST_REM   = 4'd4;
   localparam logic [PC_W-1:0] ADDR_LOOP       = 4'd5;
   localparam logic [PC_W-1:0] ADDR_COUNT      = 4'd6;
   localparam logic [PC_W-1:0] ADDR_NEXT       = 4'd7;
   localparam logic [PC_W-1:0] ADDR_JUMP       = 4'd8;
   localparam logic [PC_W-1:0] ADDR_DONE       = 4'd9;
   localparam logic [PC_W-1:0] ADDR_RETURN     = 4'd10;

   // jump conditions: when true the sequencer jumps, otherwise it runs the
   // word's operations and falls through
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CAND_OVER,
      COND_SQ_OVER,
      COND_DIV_BUSY,
      COND_REM_ZERO,
      COND_OUT_FULL
   } cond_type;

   // one control word
   typedef struct packed {
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            op_load;
      logic            op_div_init;
      logic            op_div_start;
      logic            op_div_step;
      logic            op_count_inc;
      logic            op_cand_next;
      logic            op_emit;
   } ctrl_word_type;

   // control program
   function automatic ctrl_word_type rom_word(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{cond: COND_ALWAYS, target: ADDR_IDLE, default: 1'b0};
      case (pc)
         // wait for an item, then load limit, first candidate and stride
         ADDR_IDLE: begin
            w = '{cond: COND_NO_REQ, target: ADDR_IDLE, op_load: 1'b1, default: 1'b0};
         end
         // past the limit: report, else start trial division at two
         ADDR_CHECK_CAND: begin
            w = '{cond: COND_CAND_OVER, target: ADDR_DONE, op_div_init: 1'b1,
                  default: 1'b0};
         end
         // divisor squared beyond candidate: prime
         ADDR_CHECK_DIV: begin
            w = '{cond: COND_SQ_OVER, target: ADDR_COUNT, op_div_start: 1'b1,
                  default: 1'b0};
         end
         ADDR_WAIT_DIV: begin
            w = '{cond: COND_DIV_BUSY, target: ADDR_WAIT_DIV, default: 1'b0};
         end
         // zero remainder: composite, next candidate
         ADDR_TEST_REM: begin
            w = '{cond: COND_REM_ZERO, target: ADDR_NEXT, op_div_step: 1'b1,
                  default: 1'b0};
         end
         ADDR_LOOP: begin
            w = '{cond: COND_ALWAYS, target: ADDR_CHECK_DIV, default: 1'b0};
         end
         ADDR_COUNT: begin
            w = '{cond: COND_NEVER, target: ADDR_IDLE, op_count_inc: 1'b1,
                  default: 1'b0};
         end
         ADDR_NEXT: begin
            w = '{cond: COND_NEVER, target: ADDR_IDLE, op_cand_next: 1'b1,
                  default: 1'b0};
         end
         ADDR_JUMP: begin
            w = '{cond: COND_ALWAYS, target: ADDR_CHECK_CAND, default: 1'b0};
         end
         // hold until the output register is free
         ADDR_DONE: begin
            w = '{cond: COND_OUT_FULL, target: ADDR_DONE, op_emit: 1'b1, default: 1'b0};
         end
         ADDR_RETURN: begin
            w = '{cond: COND_ALWAYS, target: ADDR_IDLE, default: 1'b0};
         end
         default: begin
            w = '{cond: COND_ALWAYS, target: ADDR_IDLE, default: 1'b0};
         end
      endcase
      return w;
   endfunction

endpackage

>>> src/spc_divider.sv
// bit-serial restoring divider that delivers the remainder
module spc_divider #(
   parameter int WIDTH = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   // one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[WIDTH-1]};
      diff = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(WIDTH);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[WIDTH-1:0];
         end else begin
            rem_in = trial[WIDTH-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy = busy_ff;
   assign remainder = rem_ff;

endmodule

>>> src/strided_prime_counter.sv
// top level of the strided prime counter: sequencer, datapath and output register
//
// Usage: write start_offset (index 0) and stride_count (index 1) on the csr
// port while idle; a stride of zero counts as one. Send an upper limit as a
// req item; one rsp item returns the number of primes among the candidates
// 2+offset, 2+offset+stride, ... up to and including the limit, saturated
// at 8191.
// A short control program tests each candidate by trial division with
// divisors 2, 3, ... while the divisor squared stays within the
// candidate. Each trial runs the shared bit-serial divider. One item is
// worked on at a time; req_ready is high only while the sequencer waits
// for an item.
// Reset (synchronous) returns the sequencer to idle, empties the output
// register and sets offset 0, stride 1. A stalled receiver holds the result
// in the output register; the next item is taken meanwhile, and its result
// waits until the register is free.
module strided_prime_counter #(
   parameter int LIMIT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [LIMIT_WIDTH-1:0]            req_upper_limit,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spc_pkg::COUNT_W-1:0]       rsp_prime_count,
   input  logic                              csr_write_enable,
   input  logic [spc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int CAND_W = LIMIT_WIDTH + 8;
   localparam int SQ_W = CAND_W + 1;

   spc_pkg::ctrl_word_type word;
   logic                            taken;
   logic                            run;
   logic [spc_pkg::PC_W-1:0]        pc_ff, pc_in;
   logic [spc_pkg::OFFSET_W-1:0]    offset_ff, offset_in;
   logic [spc_pkg::STRIDE_W-1:0]    stride_ff, stride_in;
   logic [spc_pkg::STRIDE_W-1:0]    step_ff, step_in;
   logic [LIMIT_WIDTH-1:0]          limit_ff, limit_in;
   logic [CAND_W-1:0]               cand_ff, cand_in;
   logic [CAND_W-1:0]               div_ff, div_in;
   logic [SQ_W-1:0]                 sq_ff, sq_in;
   logic [spc_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [spc_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                            div_busy;
   logic [CAND_W-1:0]               div_rem;
   logic                            out_full;

   // shared remainder unit
   spc_divider #(
      .WIDTH(CAND_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (run && word.op_div_start),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .busy     (div_busy),
      .remainder(div_rem)
   );

   // fetch and branch
   assign word = spc_pkg::rom_word(pc_ff);
   assign out_full = rsp_valid_ff && !rsp_ready;

   always_comb begin
      case (word.cond)
         spc_pkg::COND_NEVER:     taken = 1'b0;
         spc_pkg::COND_ALWAYS:    taken = 1'b1;
         spc_pkg::COND_NO_REQ:    taken = !req_valid;
         spc_pkg::COND_CAND_OVER:
            taken = cand_ff > {{(CAND_W-LIMIT_WIDTH){1'b0}}, limit_ff};
         spc_pkg::COND_SQ_OVER:   taken = sq_ff > {1'b0, cand_ff};
         spc_pkg::COND_DIV_BUSY:  taken = div_busy;
         spc_pkg::COND_REM_ZERO:  taken = div_rem == '0;
         spc_pkg::COND_OUT_FULL:  taken = out_full;
         default:                 taken = 1'b0;
      endcase
      run = !taken;
      pc_in = taken ? word.target : pc_ff + spc_pkg::PC_W'(1);
   end

   assign req_ready = word.op_load;

   // datapath operations
   always_comb begin
      limit_in = limit_ff;
      step_in = step_ff;
      cand_in = cand_ff;
      div_in = div_ff;
      sq_in = sq_ff;
      count_in = count_ff;
      if (run && word.op_load) begin
         limit_in = req_upper_limit;
         step_in = (stride_ff == '0) ? spc_pkg::STRIDE_W'(1) : stride_ff;
         cand_in = CAND_W'(offset_ff) + CAND_W'(spc_pkg::FIRST_CANDIDATE);
         count_in = '0;
      end
      if (run && word.op_div_init) begin
         div_in = CAND_W'(spc_pkg::FIRST_DIVISOR);
         sq_in = SQ_W'(spc_pkg::FIRST_DIVISOR * spc_pkg::FIRST_DIVISOR);
      end
      // (d+1)^2 = d^2 + 2d + 1
      if (run && word.op_div_step) begin
         div_in = div_ff + CAND_W'(1);
         sq_in = sq_ff + {div_ff, 1'b0} + SQ_W'(1);
      end
      if (run && word.op_count_inc && count_ff < spc_pkg::COUNT_MAX) begin
         count_in = count_ff + spc_pkg::COUNT_W'(1);
      end
      if (run && word.op_cand_next) begin
         cand_in = cand_ff + CAND_W'(step_ff);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (run && word.op_emit) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_ff;
      end
   end

   // configuration registers
   always_comb begin
      offset_in = offset_ff;
      stride_in = stride_ff;
      if (csr_write_enable && csr_index == spc_pkg::REG_START_OFFSET) begin
         offset_in = csr_write_data[spc_pkg::OFFSET_W-1:0];
      end
      if (csr_write_enable && csr_index == spc_pkg::REG_STRIDE_COUNT) begin
         stride_in = csr_write_data[spc_pkg::STRIDE_W-1:0];
      end
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= spc_pkg::ADDR_IDLE;
         rsp_valid_ff <= 1'b0;
         offset_ff <= '0;
         stride_ff <= spc_pkg::STRIDE_W'(1);
      end else begin
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff <= offset_in;
         stride_ff <= stride_in;
      end
   end

   // datapath state
   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      step_ff <= step_in;
      cand_ff <= cand_in;
      div_ff <= div_in;
      sq_ff <= sq_in;
      count_ff <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;

`ifndef SYNTHESIS
   // no item is taken while a division is under way
   assert property (@(posedge clock) disable iff (reset) req_ready |-> !div_busy)
      else $error("item accepted while divider busy");

   // a finished division moves on to the remainder test
   assert property (@(posedge clock) disable iff (reset)
      (pc_ff == spc_pkg::ADDR_WAIT_DIV && !div_busy) |=> pc_ff == spc_pkg::ADDR_TEST_REM)
      else $error("sequencer stuck after division");

   // a result is loaded once the output register is free
   assert property (@(posedge clock) disable iff (reset)
      (pc_ff == spc_pkg::ADDR_DONE && !out_full) |=> rsp_valid_ff)
      else $error("result not presented");

   // trial divisor never drops below two during a test
   assert property (@(posedge clock) disable iff (reset)
      (pc_ff == spc_pkg::ADDR_TEST_REM) |-> div_ff >= CAND_W'(spc_pkg::FIRST_DIVISOR))
      else $error("trial divisor below two");
`endif

endmodule

>>> bench/spc_checker.sv
// checker for the strided prime counter: predicts each prime count and compares it
module spc_checker #(
   parameter int LIMIT_W = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [LIMIT_W-1:0]               req_upper_limit,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [spc_pkg::COUNT_W-1:0]      rsp_prime_count,
   input  logic                             csr_write_enable,
   input  logic [spc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output int                               error_count,
   output int                               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_MAX = 10;

   // one outstanding count with the limit that caused it
   typedef struct packed {
      logic [LIMIT_W-1:0]          limit;
      logic [spc_pkg::COUNT_W-1:0] count;
   } prime_job_type;

   logic [spc_pkg::OFFSET_W-1:0] cfg_offset;
   logic [spc_pkg::STRIDE_W-1:0] cfg_stride;
   prime_job_type                expected_counts[$];

   // trial division, stopping at the first divisor that leaves no remainder
   function automatic bit is_prime(input int unsigned value);
      if (value < spc_pkg::FIRST_DIVISOR)
         return 1'b0;
      for (int unsigned d = spc_pkg::FIRST_DIVISOR; d * d <= value; d++)
         if (value % d == 0)
            return 1'b0;
      return 1'b1;
   endfunction

   // primes among 2+offset, 2+offset+stride, ... up to the limit, saturated
   function automatic logic [spc_pkg::COUNT_W-1:0] count_primes(
         input logic [LIMIT_W-1:0] lim,
         input logic [spc_pkg::OFFSET_W-1:0] offs,
         input logic [spc_pkg::STRIDE_W-1:0] strd);
      int unsigned                 step;
      logic [spc_pkg::COUNT_W-1:0] total;
      // a zero stride still advances by one
      step = (strd == 0) ? 1 : strd;
      total = '0;
      for (int unsigned cand = spc_pkg::FIRST_CANDIDATE + offs; cand <= lim; cand += step)
         if (is_prime(cand) && total != spc_pkg::COUNT_MAX)
            total++;
      return total;
   endfunction

   always @(posedge clock) begin
      prime_job_type job;
      if (reset) begin
         cfg_offset = '0;
         cfg_stride = 7'd1;
         expected_counts.delete();
         pending <= 0;
      end else begin
         // item taken: predict with the settings in force before this edge
         if (req_valid && req_ready) begin
            job.limit = req_upper_limit;
            job.count = count_primes(req_upper_limit, cfg_offset, cfg_stride);
            expected_counts.push_back(job);
         end
         // register writes, unmapped indexes change nothing
         if (csr_write_enable) begin
            case (csr_index)
               spc_pkg::REG_START_OFFSET:
                  cfg_offset = csr_write_data[spc_pkg::OFFSET_W-1:0];
               spc_pkg::REG_STRIDE_COUNT:
                  cfg_stride = csr_write_data[spc_pkg::STRIDE_W-1:0];
               default: ;
            endcase
         end
         // result taken: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               if (error_count < REPORT_MAX)
                  $display("unexpected result: prime_count %0d", rsp_prime_count);
               error_count++;
            end else begin
               job = expected_counts.pop_front();
               if (rsp_prime_count !== job.count) begin
                  if (error_count < REPORT_MAX)
                     $display("mismatch: limit %0d prime_count expected %0d actual %0d",
                              job.limit, job.count, rsp_prime_count);
                  error_count++;
               end
            end
         end
         pending <= expected_counts.size();
      end
   end

endmodule

>>> bench/tb.sv
// testbench top for the strided prime counter: clock, reset, stimulus and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_W = 16;
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 4;
   localparam int LONG_HOLD = 3000;
   localparam int TAIL_CYCLES = 200;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int RANDOM_PHASES = 5;
   localparam int ITEMS_PER_PHASE = 16;
   localparam logic [spc_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_2 = 2'd2;
   localparam logic [spc_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_3 = 2'd3;

   // kinds of random settings
   typedef enum int {
      CFG_ANY,
      CFG_DENSE,
      CFG_EVEN,
      CFG_UNIT
   } cfg_mode_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [LIMIT_W-1:0]              req_upper_limit;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [spc_pkg::COUNT_W-1:0]     rsp_prime_count;
   logic                            csr_write_enable;
   logic [spc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [spc_pkg::CSR_DATA_W-1:0]  csr_write_data;

   logic                            no_idle;
   int unsigned                     hold_ticket = 0;
   int unsigned                     cycle_count = 0;
   logic [spc_pkg::CSR_DATA_W-1:0]  cur_offset;
   logic [spc_pkg::CSR_DATA_W-1:0]  cur_stride;
   int                              error_count;
   int                              pending;

   strided_prime_counter #(
      .LIMIT_WIDTH(LIMIT_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_upper_limit (req_upper_limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_count (rsp_prime_count),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   spc_checker #(
      .LIMIT_W(LIMIT_W)
   ) prime_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_upper_limit (req_upper_limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_count (rsp_prime_count),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .error_count     (error_count),
      .pending         (pending)
   );

   // clock
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random wait per item, plus a long hold when asked
   initial begin : result_sink
      int          wait_cycles;
      int          hold_left;
      int unsigned hold_seen;
      wait_cycles = 0;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = LONG_HOLD;
         end
         if (rsp_valid && rsp_ready)
            wait_cycles = no_idle ? 0 : $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (wait_cycles > 0) begin
            wait_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // one register write; the enable stays up until set_config lowers it
   task automatic write_reg(input logic [spc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [spc_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      if (idx == spc_pkg::REG_START_OFFSET)
         cur_offset = data;
      else if (idx == spc_pkg::REG_STRIDE_COUNT)
         cur_stride = data;
   endtask

   // offset, stride, then a stray write to an unmapped index
   task automatic set_config(input logic [spc_pkg::CSR_DATA_W-1:0] offs,
                             input logic [spc_pkg::CSR_DATA_W-1:0] strd);
      write_reg(spc_pkg::REG_START_OFFSET, offs);
      write_reg(spc_pkg::REG_STRIDE_COUNT, strd);
      write_reg($urandom_range(0, 1) ? REG_UNMAPPED_2 : REG_UNMAPPED_3,
                spc_pkg::CSR_DATA_W'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // offer one limit; returns at the edge where it is taken, valid still high
   task automatic send_limit(input logic [LIMIT_W-1:0] lim);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_upper_limit <= lim;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait for every outstanding count
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // mostly small limits; full range only where every candidate is even
   function automatic logic [LIMIT_W-1:0] pick_limit();
      int   r;
      logic cheap_wide;
      r = $urandom_range(0, 9);
      cheap_wide = !cur_offset[0] && !cur_stride[0] && cur_stride >= 32;
      if (r == 0 && cheap_wide)
         return LIMIT_W'($urandom);
      if (r <= 1 && cur_stride >= 8)
         return LIMIT_W'($urandom_range(0, 1023));
      if (r <= 5)
         return LIMIT_W'($urandom_range(0, 63));
      return LIMIT_W'($urandom_range(0, 255));
   endfunction

   initial begin : stimulus
      logic [spc_pkg::CSR_DATA_W-1:0] offs;
      logic [spc_pkg::CSR_DATA_W-1:0] strd;
      cfg_mode_type                   mode;
      reset = 1'b1;
      req_valid = 1'b0;
      req_upper_limit = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      no_idle = 1'b0;
      cur_offset = '0;
      cur_stride = 7'd1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings, limits below two and a few small ones
      send_limit(16'd0);
      send_limit(16'd1);
      send_limit(16'd2);
      send_limit(16'd3);
      send_limit(16'd4);
      send_limit(16'd13);
      send_limit(16'd100);
      drain();

      // highest offset and a stride of 64; first limit below first candidate
      set_config(7'd63, 7'd64);
      send_limit(16'd64);
      send_limit(16'd65);
      send_limit(16'd129);
      send_limit(16'd4000);
      drain();

      // even candidates only, so full-range limits stay short; offset bit 6 dropped
      set_config(7'h40, 7'd64);
      no_idle <= 1'b1;
      send_limit(16'hFFFF);
      send_limit(16'h8000);
      drain();

      // zero stride behaves as one
      no_idle <= 1'b0;
      set_config(7'd5, 7'd0);
      send_limit(16'd5);
      send_limit(16'd50);
      send_limit(16'd200);
      drain();

      // largest stride the 7-bit register holds
      set_config(7'd1, 7'h7F);
      send_limit(16'd2);
      send_limit(16'd3);
      send_limit(16'd8000);
      drain();

      // long receiver hold while short items keep coming
      set_config(7'd0, 7'd1);
      hold_ticket <= hold_ticket + 1;
      send_limit(16'd0);
      send_limit(16'd1);
      send_limit(16'd2);
      send_limit(16'd3);
      send_limit(16'd7);
      drain();

      // random settings, each followed by a batch of random limits
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = cfg_mode_type'($urandom_range(0, 3));
         case (mode)
            CFG_ANY: begin
               offs = spc_pkg::CSR_DATA_W'($urandom_range(0, 127));
               strd = spc_pkg::CSR_DATA_W'($urandom_range(0, 127));
            end
            CFG_DENSE: begin
               offs = spc_pkg::CSR_DATA_W'($urandom_range(0, 7));
               strd = spc_pkg::CSR_DATA_W'($urandom_range(1, 4));
            end
            CFG_EVEN: begin
               offs = spc_pkg::CSR_DATA_W'(2 * $urandom_range(0, 63));
               strd = spc_pkg::CSR_DATA_W'(2 * $urandom_range(16, 63));
            end
            default: begin
               offs = spc_pkg::CSR_DATA_W'($urandom_range(0, 127));
               strd = spc_pkg::CSR_DATA_W'($urandom_range(0, 1));
            end
         endcase
         set_config(offs, strd);
         no_idle <= ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_limit(pick_limit());
         drain();
      end

      // settle, then verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> strided_prime_counter.f
src/spc_pkg.sv
src/spc_divider.sv
src/strided_prime_counter.sv
bench/spc_checker.sv
bench/tb.sv
